>>> rtl/core/csbd_pkg.sv
// csbd_pkg: shared constants for the charger status blink decoder.
// Status codes, register indexes, reset values and stream packing widths.
// No dependencies.
`default_nettype none

package csbd_pkg;

	// Default sizes of the timers and the edge counter
	localparam int CSBD_TIMER_BITS = 16;
	localparam int CSBD_COUNT_BITS = 8;

	// Configuration register widths
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int WIN_LEN_W    = 16;
	localparam int THRESH_W     = 8;
	localparam int HALF_PER_W   = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_MIN   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_MAX   = 2'd3;

	// Register reset values
	localparam logic [WIN_LEN_W-1:0]  RST_WINDOW_LEN = 16'd4000;
	localparam logic [THRESH_W-1:0]   RST_THRESHOLD  = 8'd3;
	localparam logic [HALF_PER_W-1:0] RST_HALF_MIN   = 16'd900;
	localparam logic [HALF_PER_W-1:0] RST_HALF_MAX   = 16'd1100;

	// Status codes
	localparam int CODE_W = 3;
	typedef logic [CODE_W-1:0] status_code_t;
	localparam status_code_t CODE_UNDEF    = 3'd0;
	localparam status_code_t CODE_CHARGING = 3'd1;
	localparam status_code_t CODE_FULL     = 3'd2;
	localparam status_code_t CODE_SLEEP    = 3'd3;
	localparam status_code_t CODE_ERROR    = 3'd4;

	// Stream packing
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;
	localparam int IN_STAT_BIT  = 0;
	localparam int IN_PBAD_BIT  = 1;
	localparam int OUT_STABLE_LO = 0;
	localparam int OUT_RAW_LO    = 3;
	localparam int OUT_BLINK_BIT = 6;

endpackage

`default_nettype wire

>>> rtl/core/charger_status_blink_decoder_unit.sv
// charger_status_blink_decoder_unit: top level of the charger status blink decoder.
// Uses csbd_pkg for codes, register indexes and packing; checked by csbd_checker.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  s_      | in  | s_tvalid/tready  | s_tdata: stat_level, power_bad_level
//  m_      | out | m_tvalid/tready  | m_tdata: stable_status, raw_status, blink_seen
//  cfg_    | in  | cfg_we (no wait) | cfg_index, cfg_wdata
//
// One item per cycle unless the receiver stalls; the result appears the cycle after acceptance.
// The tick update logic feeds the single result register.
// The input is taken whenever the result register is empty or being drained.
// A stall downstream holds the result and stops intake; no item is dropped.
// arst_n clears all timers, counters and codes and loads register defaults.
`default_nettype none

module charger_status_blink_decoder_unit
	import csbd_pkg::*;
#(
	parameter int TIMER_BITS = CSBD_TIMER_BITS,
	parameter int COUNT_BITS = CSBD_COUNT_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input item stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_DATA_W-1:0]   s_tdata,  // [0] stat_level, [1] power_bad_level
	// result item stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_DATA_W-1:0]       m_tdata,  // [2:0] stable_status, [5:3] raw_status,
	                                              // [6] blink_seen
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	// Compare widths cover both the counter/timer and the register it meets
	localparam int TCMP_W = (TIMER_BITS > HALF_PER_W) ? TIMER_BITS : HALF_PER_W;
	localparam int CCMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

	// Configuration registers
	logic [WIN_LEN_W-1:0]  win_len_q;
	logic [THRESH_W-1:0]   thresh_q;
	logic [HALF_PER_W-1:0] half_min_q;
	logic [HALF_PER_W-1:0] half_max_q;

	// Decoder state
	logic                  last_stat_q;
	logic [COUNT_BITS-1:0] edge_cnt_q;
	logic                  blink_q;
	status_code_t          raw_q;
	status_code_t          stable_q;
	logic [TIMER_BITS-1:0] win_tmr_q;
	logic [TIMER_BITS-1:0] half_tmr_q;
	logic [TIMER_BITS-1:0] settle_tmr_q;

	// Result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_DATA_W-1:0] out_word;

	logic stat, pbad, accept;
	logic [TIMER_BITS-1:0] win_inc, half_inc, settle_inc;
	logic [TIMER_BITS-1:0] win_nxt, half_nxt, settle_nxt;
	logic [COUNT_BITS-1:0] cnt_edge, cnt_pwr, cnt_nxt;
	logic                  edge_seen, qualified, win_end, blink_nxt;
	status_code_t          raw_nxt, stable_nxt;

	assign stat     = s_tdata[IN_STAT_BIT];
	assign pbad     = s_tdata[IN_PBAD_BIT];
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q  <= RST_WINDOW_LEN;
			thresh_q   <= RST_THRESHOLD;
			half_min_q <= RST_HALF_MIN;
			half_max_q <= RST_HALF_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LEN: win_len_q  <= cfg_wdata[WIN_LEN_W-1:0];
				REG_THRESHOLD:  thresh_q   <= cfg_wdata[THRESH_W-1:0];
				REG_HALF_MIN:   half_min_q <= cfg_wdata[HALF_PER_W-1:0];
				REG_HALF_MAX:   half_max_q <= cfg_wdata[HALF_PER_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- tick update ----
	always_comb begin
		// saturating millisecond timers
		win_inc    = (win_tmr_q == '1) ? win_tmr_q : win_tmr_q + 1'b1;
		half_inc   = (half_tmr_q == '1) ? half_tmr_q : half_tmr_q + 1'b1;
		settle_inc = (settle_tmr_q == '1) ? settle_tmr_q : settle_tmr_q + 1'b1;

		// pin edge: qualify on half-period window, restart half-period timer
		edge_seen = (stat != last_stat_q);
		qualified = edge_seen
			&& (TCMP_W'(half_inc) >= TCMP_W'(half_min_q))
			&& (TCMP_W'(half_inc) <= TCMP_W'(half_max_q))
			&& (edge_cnt_q != '1);
		cnt_edge  = qualified ? edge_cnt_q + 1'b1 : edge_cnt_q;
		half_nxt  = edge_seen ? '0 : half_inc;

		// no power-good: count held at zero
		cnt_pwr = pbad ? '0 : cnt_edge;

		// window end: blink decision and count clear
		win_end   = (TCMP_W'(win_inc) >= TCMP_W'(win_len_q));
		blink_nxt = win_end ? (CCMP_W'(cnt_pwr) >= CCMP_W'(thresh_q)) : blink_q;
		cnt_nxt   = win_end ? '0 : cnt_pwr;
		win_nxt   = win_end ? '0 : win_inc;

		// classification
		if (blink_nxt)
			raw_nxt = CODE_ERROR;
		else if (!stat)
			raw_nxt = CODE_CHARGING;
		else if (!pbad)
			raw_nxt = CODE_FULL;
		else
			raw_nxt = CODE_SLEEP;

		// settle: stable follows raw once it has held long enough
		settle_nxt = (raw_nxt != raw_q) ? '0 : settle_inc;
		stable_nxt = (TCMP_W'(settle_nxt) >= TCMP_W'(half_max_q)) ? raw_nxt : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stat_q  <= 1'b0;
			edge_cnt_q   <= '0;
			blink_q      <= 1'b0;
			raw_q        <= CODE_UNDEF;
			stable_q     <= CODE_UNDEF;
			win_tmr_q    <= '0;
			half_tmr_q   <= '0;
			settle_tmr_q <= '0;
		end else if (accept) begin
			last_stat_q  <= stat;
			edge_cnt_q   <= cnt_nxt;
			blink_q      <= blink_nxt;
			raw_q        <= raw_nxt;
			stable_q     <= stable_nxt;
			win_tmr_q    <= win_nxt;
			half_tmr_q   <= half_nxt;
			settle_tmr_q <= settle_nxt;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word packing, spare bits zero
	always_comb begin
		out_word = '0;
		out_word[OUT_STABLE_LO +: CODE_W] = stable_nxt;
		out_word[OUT_RAW_LO +: CODE_W]    = raw_nxt;
		out_word[OUT_BLINK_BIT]           = blink_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= out_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/csbd_checker.sv
// csbd_checker: port-level assertions for charger_status_blink_decoder_unit.
// Uses csbd_pkg; bound to the top level at the end of this file.
`default_nettype none

module csbd_checker
	import csbd_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted item always yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item gave no result");

	// an empty result register never blocks intake
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("intake blocked with no pending result");

	// raw status is error exactly when blinking is flagged
	a_err_blink: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[OUT_RAW_LO +: CODE_W] == CODE_ERROR)
			== m_tdata[OUT_BLINK_BIT]))
		else $error("error code and blink flag disagree");

	// raw status is never undefined once an item has been classified
	a_raw_def: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_RAW_LO +: CODE_W] != CODE_UNDEF))
		else $error("raw status undefined in a result");

endmodule

bind charger_status_blink_decoder_unit csbd_checker u_csbd_checker (.*);

`default_nettype wire

>>> verif/charger_status_blink_decoder_unit_test.sv
// charger_status_blink_decoder_unit_test: self-checking bench for the charger status blink decoder.
// Sends tick items and register writes, predicts each result item, compares field by field.
// Depends on csbd_pkg and charger_status_blink_decoder_unit.

module charger_status_blink_decoder_unit_test;
	import csbd_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	// receiver hold-off long enough to back the block up to its input
	localparam int LONG_HOLD    = 60;
	// about 870 items; the limit leaves ample room for gaps and stalls on every item
	localparam longint CYCLE_LIMIT = 60_000;
	// cap on printed mismatches, all of them still count
	localparam int MAX_REPORTS  = 20;

	typedef logic [CSBD_TIMER_BITS-1:0] ms_timer_t;
	typedef logic [CSBD_COUNT_BITS-1:0] edge_count_t;

	typedef struct packed {
		logic         blink;
		status_code_t raw;
		status_code_t stable;
	} tick_report_t;

	// ports
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;  // [0] stat_level, [1] power_bad_level
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;         // [2:0] stable, [5:3] raw, [6] blink_seen
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_WINDOW_LEN;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// decoder state as the bench sees it, starting from the reset values
	logic [WIN_LEN_W-1:0]  cfg_window    = RST_WINDOW_LEN;
	logic [THRESH_W-1:0]   cfg_threshold = RST_THRESHOLD;
	logic [HALF_PER_W-1:0] cfg_half_min  = RST_HALF_MIN;
	logic [HALF_PER_W-1:0] cfg_half_max  = RST_HALF_MAX;
	logic                  last_level    = 1'b0;
	logic                  blink_state   = 1'b0;
	edge_count_t           edge_tally    = '0;
	status_code_t          raw_state     = CODE_UNDEF;
	status_code_t          stable_state  = CODE_UNDEF;
	ms_timer_t             window_ms     = '0;
	ms_timer_t             half_ms       = '0;
	ms_timer_t             settle_ms     = '0;

	tick_report_t expected_reports[$];
	int           mismatches   = 0;
	longint       cycle_count  = 0;
	int           ticks_sent   = 0;
	bit           calm         = 1'b0;  // no idling on either side once set
	bit           hold_off_req = 1'b0;  // asks the receiver for one long hold-off
	logic         pin_level    = 1'b0;  // status pin level of the last item sent

	charger_status_blink_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// millisecond timers stick at all ones rather than wrapping
	function automatic ms_timer_t ms_advance(input ms_timer_t t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	// one millisecond tick of the decoder; updates the bench copy of the state
	function automatic tick_report_t decode_tick(input logic level, input logic power_bad);
		status_code_t prev_raw;
		window_ms = ms_advance(window_ms);
		half_ms   = ms_advance(half_ms);
		settle_ms = ms_advance(settle_ms);

		// pin edge: counts only if the half-period lay inside [min, max]
		if (level != last_level) begin
			last_level = level;
			if (half_ms >= cfg_half_min && half_ms <= cfg_half_max && edge_tally != '1)
				edge_tally = edge_tally + 1'b1;
			half_ms = '0;
		end

		// no blink counting without good power
		if (power_bad)
			edge_tally = '0;

		// window end: decide on blinking, start a fresh count
		if (window_ms >= cfg_window) begin
			window_ms   = '0;
			blink_state = (edge_tally >= cfg_threshold);
			edge_tally  = '0;
		end

		prev_raw = raw_state;
		if (blink_state)
			raw_state = CODE_ERROR;
		else if (!level)
			raw_state = CODE_CHARGING;
		else if (!power_bad)
			raw_state = CODE_FULL;
		else
			raw_state = CODE_SLEEP;

		// stable status only follows once the raw status has held long enough
		if (prev_raw != raw_state)
			settle_ms = '0;
		if (settle_ms >= cfg_half_max)
			stable_state = raw_state;

		return '{blink: blink_state, raw: raw_state, stable: stable_state};
	endfunction

	// ---------------------------------------------------------------------
	// Scoreboard: intake first, so even a result shown in its intake cycle finds its entry
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		tick_report_t want;
		tick_report_t got;
		if (arst_n && s_tvalid && s_tready)
			expected_reports.push_back(decode_tick(s_tdata[IN_STAT_BIT], s_tdata[IN_PBAD_BIT]));
		if (arst_n && m_tvalid && m_tready) begin
			got.stable = m_tdata[OUT_STABLE_LO +: CODE_W];
			got.raw    = m_tdata[OUT_RAW_LO +: CODE_W];
			got.blink  = m_tdata[OUT_BLINK_BIT];
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result item with none expected: stable %0d raw %0d blink %0d",
						$time, got.stable, got.raw, got.blink);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected stable %0d raw %0d blink %0d, got stable %0d raw %0d blink %0d",
							$time, want.stable, want.raw, want.blink,
							got.stable, got.raw, got.blink);
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: short random stalls, or one long counted hold-off on request
	// ---------------------------------------------------------------------
	initial begin : receiver
		int stall;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				for (int k = 0; k < LONG_HOLD; k++)
					@(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 5);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------------

	// offer one tick item, with an occasional gap first; returns at the edge it is taken
	task automatic offer_tick(input logic level, input logic power_bad);
		int gap;
		logic [IN_DATA_W-1:0] word;
		word = '0;
		word[IN_STAT_BIT] = level;
		word[IN_PBAD_BIT] = power_bad;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pin_level = level;
		ticks_sent++;
	endtask

	// stop offering and wait for every outstanding result item
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		// block is idle here, so the bench copy can change at the same edge
		case (idx)
			REG_WINDOW_LEN: cfg_window    = value;
			REG_THRESHOLD:  cfg_threshold = value[THRESH_W-1:0];
			REG_HALF_MIN:   cfg_half_min  = value;
			REG_HALF_MAX:   cfg_half_max  = value;
			default: ;
		endcase
	endtask

	task automatic load_config(input int win, input int thr, input int hmin, input int hmax);
		wait_results_done();
		write_reg(REG_WINDOW_LEN, CFG_DATA_W'(win));
		write_reg(REG_THRESHOLD,  CFG_DATA_W'(thr));
		write_reg(REG_HALF_MIN,   CFG_DATA_W'(hmin));
		write_reg(REG_HALF_MAX,   CFG_DATA_W'(hmax));
	endtask

	// blink pattern: each edge follows the last after a half-period in [hp_lo, hp_hi]
	task automatic blink_run(input int edges_n, input int hp_lo, input int hp_hi,
			input int pbad_pct);
		int hp;
		logic level;
		for (int e = 0; e < edges_n; e++) begin
			hp    = $urandom_range(hp_lo, hp_hi);
			level = ~pin_level;
			repeat (hp) offer_tick(level, $urandom_range(0, 99) < pbad_pct);
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// reset values: every pin combination, stable stays undefined (1100 ms settle)
	task automatic test_reset_defaults();
		offer_tick(1'b0, 1'b0);  // charging
		offer_tick(1'b1, 1'b0);  // battery full
		offer_tick(1'b1, 1'b1);  // sleep
		offer_tick(1'b0, 1'b1);  // charging, power bad
		offer_tick(1'b1, 1'b0);
		offer_tick(1'b1, 1'b0);
	endtask

	// minimum above maximum: even perfect edges never qualify
	task automatic test_min_above_max();
		load_config(10, 1, 5, 3);
		for (int i = 0; i < 12; i++)
			offer_tick(((i / 4) % 2) == 0, 1'b0);
	endtask

	// zero window ends a window every tick; zero threshold then always blinks
	task automatic test_zero_window();
		// threshold written with junk in the upper byte, which must be dropped
		load_config(0, 16'hFF00, 0, 0);
		offer_tick(1'b0, 1'b0);
		offer_tick(1'b1, 1'b1);
		offer_tick(1'b1, 1'b0);
		offer_tick(1'b0, 1'b1);
		// threshold one: any edge blinks at once, unless power bad clears it
		load_config(0, 1, 0, 16'hFFFF);
		offer_tick(1'b1, 1'b0);
		offer_tick(1'b1, 1'b0);
		offer_tick(1'b0, 1'b1);
		offer_tick(1'b1, 1'b0);
		offer_tick(1'b1, 1'b1);
		offer_tick(1'b0, 1'b0);
	endtask

	// edge count saturation: window timer is zero after the previous test, so
	// ~260 qualified edges land in one window; a wrapping count would miss 255
	task automatic test_count_saturation();
		load_config(260, 255, 0, 1);
		repeat (262) offer_tick(~pin_level, 1'b0);
	endtask

	// long receiver hold-off while items keep coming, then a full pause
	task automatic test_backpressure();
		load_config(12, 2, 2, 3);
		hold_off_req = 1'b1;
		blink_run(14, 2, 3, 0);
		wait_results_done();
	endtask

	// random settings, mostly clean blink runs, some noise and broken runs
	task automatic test_random_phases();
		int win, thr, hmin, hmax, lo, hi, start, pick, n;
		for (int phase = 0; phase < 7; phase++) begin
			win  = $urandom_range(6, 40);
			thr  = $urandom_range(1, 4);
			hmin = $urandom_range(1, 4);
			hmax = hmin + $urandom_range(0, 3);
			case (phase)
				2: begin hmin = 5; hmax = 3; end  // inverted range
				4: begin hmin = 0; hmax = 0; end  // stable follows every tick
				5: begin win = 1; thr = 1; end    // window ends every tick
				6: calm = 1'b1;                   // final stretch without idling
				default: ;
			endcase
			load_config(win, thr, hmin, hmax);
			lo = (hmin > hmax || hmin < 1) ? 1 : hmin;
			hi = (hmin > hmax || hmax < lo) ? 6 : hmax;
			start = ticks_sent;
			while (ticks_sent - start < 70) begin
				pick = $urandom_range(0, 9);
				n    = $urandom_range(3, 8);
				if (pick < 6) begin
					blink_run(n, lo, hi, 4);
				end else if (pick < 8) begin
					repeat (n) offer_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else if (pick == 8) begin
					// half-periods just past the accepted range
					blink_run(n, hi + 1, hi + 4, 0);
				end else begin
					// power glitches through an otherwise good pattern
					blink_run(n, lo, hi, 50);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : run_all
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_min_above_max();
		test_zero_window();
		test_count_saturation();
		test_backpressure();
		test_random_phases();
		wait_results_done();
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> charger_status_blink_decoder_unit.f
rtl/core/csbd_pkg.sv
rtl/core/charger_status_blink_decoder_unit.sv
rtl/core/csbd_checker.sv
verif/charger_status_blink_decoder_unit_test.sv
